@@ rtl/dhsg_pkg.sv @@
// ----------------------------------------------------------------------------
// dhsg_pkg
// Shared types and constants of the duplicate detector hash set.
// ----------------------------------------------------------------------------
package dhsg_pkg;

    // Commands carried by an input item
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Size register
    localparam int unsigned      TABLE_BITS_W     = 4;
    localparam logic [3:0]       TABLE_BITS_RESET = 4'd10;

    // Defaults for the top-level parameters
    localparam int unsigned TABLE_DEPTH_DEF = 1024;
    localparam int unsigned STAMP_BITS_DEF  = 16;

    typedef struct packed {
        logic        command;
        logic [63:0] key;
    } t_in_item;

    typedef struct packed {
        logic is_new;
        logic table_full;
    } t_out_item;

    // Item leaving the hash pipeline
    typedef struct packed {
        logic        command;
        logic [63:0] key;
        logic [63:0] hash;
    } t_hashed;

endpackage

@@ rtl/dhsg_ram.sv @@
// ----------------------------------------------------------------------------
// dhsg_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dhsg_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/dhsg_hash.sv @@
// ----------------------------------------------------------------------------
// dhsg_hash
// Five-stage splitmix64 finalizer pipeline; each 64-bit multiply is split
// into three 32x32 partial products and summed in the following stage.
// ----------------------------------------------------------------------------
module dhsg_hash (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dhsg_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output dhsg_pkg::t_hashed o_item
);

    localparam int unsigned STAGES = 5;
    localparam logic [63:0] ADD_C  = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MUL_1  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MUL_2  = 64'h94D049BB133111EB;
    localparam int unsigned SH_1   = 30;
    localparam int unsigned SH_2   = 27;
    localparam int unsigned SH_3   = 31;

    logic [STAGES-1:0]  r_v;
    dhsg_pkg::t_in_item r_item [STAGES];

    logic [63:0] r_a_x;
    logic [63:0] r_b_p0;
    logic [31:0] r_b_p1;
    logic [31:0] r_b_p2;
    logic [63:0] r_c_x;
    logic [63:0] r_d_p0;
    logic [31:0] r_d_p1;
    logic [31:0] r_d_p2;
    logic [63:0] r_e_hash;

    logic        w_adv;
    logic [63:0] w_sum;
    logic [63:0] w_m1_p1;
    logic [63:0] w_m1_p2;
    logic [63:0] w_h1;
    logic [63:0] w_m2_p1;
    logic [63:0] w_m2_p2;
    logic [63:0] w_h2;

    // The whole pipe advances unless the last stage holds an item nobody takes
    assign w_adv   = !r_v[STAGES-1] || i_ready;
    assign o_ready = w_adv;

    assign w_sum   = i_item.key + ADD_C;
    assign w_m1_p1 = r_a_x[63:32] * MUL_1[31:0];
    assign w_m1_p2 = r_a_x[31:0]  * MUL_1[63:32];
    assign w_h1    = r_b_p0 + {r_b_p1 + r_b_p2, 32'h0};
    assign w_m2_p1 = r_c_x[63:32] * MUL_2[31:0];
    assign w_m2_p2 = r_c_x[31:0]  * MUL_2[63:32];
    assign w_h2    = r_d_p0 + {r_d_p1 + r_d_p2, 32'h0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_item[0] <= i_item;
            for (int s = 1; s < STAGES; s++) begin
                r_item[s] <= r_item[s-1];
            end
            r_a_x    <= w_sum ^ (w_sum >> SH_1);
            r_b_p0   <= r_a_x[31:0] * MUL_1[31:0];
            r_b_p1   <= w_m1_p1[31:0];
            r_b_p2   <= w_m1_p2[31:0];
            r_c_x    <= w_h1 ^ (w_h1 >> SH_2);
            r_d_p0   <= r_c_x[31:0] * MUL_2[31:0];
            r_d_p1   <= w_m2_p1[31:0];
            r_d_p2   <= w_m2_p2[31:0];
            r_e_hash <= w_h2 ^ (w_h2 >> SH_3);
        end
    end

    assign o_valid        = r_v[STAGES-1];
    assign o_item.command = r_item[STAGES-1].command;
    assign o_item.key     = r_item[STAGES-1].key;
    assign o_item.hash    = r_e_hash;

endmodule

@@ rtl/dedup_hash_set_generation.sv @@
// ----------------------------------------------------------------------------
// dedup_hash_set_generation
// Duplicate detector: open-addressing set of 64-bit keys with linear probing
// and generation stamps, so that a clear normally only advances the generation.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+--------------------------
//  in      | input     | i_in_valid  / o_in_ready   | i_in_item  (command, key)
//  out     | output    | o_out_valid / i_out_ready  | o_out_item (is_new, table_full)
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_data (table_bits)
//
// Flow: the hash pipeline overlaps with the probing of the previous item. The
//   probe engine launches an insert by reading its home slot, then judges
//   one slot per read of the slot memory until it finds a free slot, the key
//   or the end of the slots in use. A clear command advances the generation.
// Reset: a clearing pass writes every one of the 2^floor(log2(TABLE_DEPTH))
//   slots of the memory, one a cycle; the same pass follows a size write and
//   a generation wrap. No item is accepted during the pass.
// Stalls: the output register takes the result of the next item while the
//   current one is being taken; the hash pipe holds when its last stage waits.
// ----------------------------------------------------------------------------
module dedup_hash_set_generation #(
    parameter int unsigned TABLE_DEPTH = dhsg_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned STAMP_BITS  = dhsg_pkg::STAMP_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  dhsg_pkg::t_in_item                   i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output dhsg_pkg::t_out_item                  o_out_item,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [dhsg_pkg::TABLE_BITS_W-1:0]    i_cfg_data
);

    // Largest usable log2 size: the biggest power of two not above TABLE_DEPTH
    localparam int unsigned MAX_BITS  = $clog2(TABLE_DEPTH + 1) - 1;
    localparam int unsigned AW        = MAX_BITS;
    localparam int unsigned RAM_DEPTH = 1 << AW;
    localparam int unsigned WORD_W    = 64 + STAMP_BITS;

    localparam logic [STAMP_BITS-1:0] GEN_FIRST = STAMP_BITS'(1);

    // Probe engine states
    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_PROBE = 1'b1;

    // Control state
    logic                                 r_state,      n_state;
    logic [STAMP_BITS-1:0]                r_gen,        n_gen;
    logic [dhsg_pkg::TABLE_BITS_W-1:0]    r_tb,         n_tb;
    logic                                 r_clr_active, n_clr_active;
    logic [AW-1:0]                        r_clr_addr,   n_clr_addr;
    logic                                 r_out_valid,  n_out_valid;

    // Payload state
    logic [63:0]                          r_key,        n_key;
    logic [AW-1:0]                        r_slot,       n_slot;
    logic [AW-1:0]                        r_idx,        n_idx;
    dhsg_pkg::t_out_item                  r_out_item,   n_out_item;

    // Hash pipeline
    logic                                 w_hash_in_valid;
    logic                                 w_hash_in_ready;
    logic                                 w_hash_valid;
    dhsg_pkg::t_hashed                    w_hash_item;

    // Slot memory: {stamp, key} per slot
    logic                                 w_we;
    logic [AW-1:0]                        w_waddr;
    logic [WORD_W-1:0]                    w_wdata;
    logic [AW-1:0]                        w_raddr;
    logic [WORD_W-1:0]                    w_rdata;

    logic [4:0]                           w_eb;
    logic [AW-1:0]                        w_mask;
    logic [AW-1:0]                        w_home;
    logic                                 w_out_free;
    logic                                 w_take;
    logic [STAMP_BITS-1:0]                w_rd_stamp;
    logic [63:0]                          w_rd_key;
    logic                                 w_free;
    logic                                 w_match;
    logic                                 w_last;
    logic                                 w_done;

    // ------------------------------------------------------------------------
    // Hashing: items enter here; hold them off while the memory is cleared
    // ------------------------------------------------------------------------
    assign w_hash_in_valid = i_in_valid && !r_clr_active;
    assign o_in_ready      = w_hash_in_ready && !r_clr_active;

    dhsg_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_hash_in_valid),
        .o_ready (w_hash_in_ready),
        .i_item  (i_in_item),
        .o_valid (w_hash_valid),
        .i_ready (w_take),
        .o_item  (w_hash_item)
    );

    // ------------------------------------------------------------------------
    // Table size in use: clamp table_bits to [1, MAX_BITS], build the mask
    // ------------------------------------------------------------------------
    always_comb begin
        w_eb = {1'b0, r_tb};
        if (w_eb == 5'd0) begin
            w_eb = 5'd1;
        end
        if (w_eb > 5'(MAX_BITS)) begin
            w_eb = 5'(MAX_BITS);
        end
        for (int i = 0; i < AW; i++) begin
            w_mask[i] = (5'(i) < w_eb);
        end
    end

    assign w_home = w_hash_item.hash[AW-1:0] & w_mask;

    // ------------------------------------------------------------------------
    // Probe engine
    // A slot read is issued in one cycle and judged in the next. While
    // judging, the read of the following slot is already under way.
    // ------------------------------------------------------------------------
    // The output register is free if empty or being emptied at this edge.
    // Only the engine fills it, and only one item is in the engine, so a slot
    // that is free at launch is still free when the insert completes.
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_take     = (r_state == ST_IDLE) && !r_clr_active && w_out_free && w_hash_valid;

    assign w_rd_stamp = w_rdata[WORD_W-1:64];
    assign w_rd_key   = w_rdata[63:0];
    assign w_free     = (w_rd_stamp != r_gen);
    assign w_match    = (w_rd_key == r_key);
    assign w_last     = (r_idx == w_mask);
    assign w_done     = (r_state == ST_PROBE) && (w_free || w_match || w_last);

    // Read address: the home slot at launch, then the next slot while probing
    assign w_raddr = (r_state == ST_IDLE) ? w_home : ((r_slot + AW'(1)) & w_mask);

    // Write port: the clearing pass has it to itself; otherwise store a new key
    always_comb begin
        if (r_clr_active) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else begin
            w_we    = (r_state == ST_PROBE) && w_free;
            w_waddr = r_slot;
            w_wdata = {r_gen, r_key};
        end
    end

    dhsg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAM_DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_gen        = r_gen;
        n_tb         = r_tb;
        n_clr_active = r_clr_active;
        n_clr_addr   = r_clr_addr;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_key        = r_key;
        n_slot       = r_slot;
        n_idx        = r_idx;
        n_out_item   = r_out_item;

        // Advance the clearing pass; finish after the last slot
        if (r_clr_active) begin
            n_clr_addr = r_clr_addr + AW'(1);
            if (r_clr_addr == '1) begin
                n_clr_active = 1'b0;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    if (w_hash_item.command == dhsg_pkg::CMD_CLEAR) begin
                        // New generation empties the set; on wrap, wipe the stamps
                        n_gen = r_gen + GEN_FIRST;
                        if (n_gen == '0) begin
                            n_gen        = GEN_FIRST;
                            n_clr_active = 1'b1;
                            n_clr_addr   = '0;
                        end
                        n_out_valid           = 1'b1;
                        n_out_item.is_new     = 1'b0;
                        n_out_item.table_full = 1'b0;
                    end else begin
                        n_key   = w_hash_item.key;
                        n_slot  = w_home;
                        n_idx   = '0;
                        n_state = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                if (w_done) begin
                    n_state               = ST_IDLE;
                    n_out_valid           = 1'b1;
                    n_out_item.is_new     = w_free;
                    n_out_item.table_full = !w_free && !w_match;
                end else begin
                    n_slot = (r_slot + AW'(1)) & w_mask;
                    n_idx  = r_idx + AW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Size write: empty the set and restart the clearing pass
        if (i_cfg_valid) begin
            n_tb         = i_cfg_data;
            n_gen        = GEN_FIRST;
            n_clr_active = 1'b1;
            n_clr_addr   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_gen        <= GEN_FIRST;
            r_tb         <= dhsg_pkg::TABLE_BITS_RESET;
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_gen        <= n_gen;
            r_tb         <= n_tb;
            r_clr_active <= n_clr_active;
            r_clr_addr   <= n_clr_addr;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_slot     <= n_slot;
        r_idx      <= n_idx;
        r_out_item <= n_out_item;
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // Probing must never overlap the clearing pass: both use the write port
    a_no_probe_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_state == ST_PROBE) && r_clr_active))
        else $error("probe engine active during clearing pass");

    // Generation zero marks an empty slot and is never current
    a_gen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gen != '0)
        else $error("generation is zero");

    // A finished insert must find the output register free
    a_out_free_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> w_out_free)
        else $error("insert result would overwrite a pending item");

    // A launched insert enters probing in the next cycle
    a_take_to_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && (w_hash_item.command == dhsg_pkg::CMD_INSERT) && !i_cfg_valid)
            |=> (r_state == ST_PROBE))
        else $error("insert launched without probing");

endmodule

@@ bench/dedup_hash_set_generation_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_hash_set_generation_tb
// Self-checking bench for the duplicate detector. A shadow copy of the hash
// set, its stamps and its generation predicts the verdict for every accepted
// item. Directed items cover full tables, clears and a generation wrap, and
// random phases then run across the size settings, most under random idling
// on both channels.
// ----------------------------------------------------------------------------
module dedup_hash_set_generation_tb;

    localparam int unsigned DEPTH        = dhsg_pkg::TABLE_DEPTH_DEF;
    // narrow stamps, so that a generation wrap takes only 255 clears
    localparam int unsigned SBITS        = 8;
    // log2 of the largest power of two that fits in the table
    localparam int unsigned MAX_BITS     = $clog2(DEPTH + 1) - 1;
    // no handshake for this long means the block has hung
    localparam int unsigned STALL_LIMIT  = 20000;
    // pause once everything has drained, before a size write and at the end
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned TBW          = dhsg_pkg::TABLE_BITS_W;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    dhsg_pkg::t_in_item      in_item   = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    dhsg_pkg::t_out_item     out_item;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [TBW-1:0]          cfg_data  = '0;

    // Shadow copy of the set
    logic [63:0]             shadow_keys  [DEPTH];
    logic [SBITS-1:0]        shadow_stamp [DEPTH];
    logic [SBITS-1:0]        shadow_gen;
    logic [TBW-1:0]          shadow_bits;

    dhsg_pkg::t_in_item  pending_items [$];   // items still to be offered
    dhsg_pkg::t_out_item owed_verdicts [$];   // verdicts predicted, not yet seen
    logic [63:0]         key_pool [$];        // keys reused within a phase

    int unsigned items_queued = 0;
    int unsigned items_taken  = 0;
    int unsigned mismatches   = 0;
    int unsigned in_gap       = 0;
    int unsigned out_stall    = 0;
    int unsigned quiet_cycles = 0;
    bit          calm         = 1'b0;  // suppress idling on both sides

    dedup_hash_set_generation #(
        .TABLE_DEPTH (DEPTH),
        .STAMP_BITS  (SBITS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------------

    // Drop every stamp and restart at generation one
    function automatic void empty_shadow();
        foreach (shadow_stamp[i]) shadow_stamp[i] = '0;
        shadow_gen = SBITS'(1);
    endfunction

    // Size in use: zero reads as one, anything above the table saturates
    function automatic int unsigned live_bits();
        if (shadow_bits < 1) return 1;
        if (shadow_bits > MAX_BITS) return MAX_BITS;
        return shadow_bits;
    endfunction

    // Work out the verdict for one accepted item and update the shadow set
    function automatic void judge_item(input dhsg_pkg::t_in_item it);
        dhsg_pkg::t_out_item verdict;
        logic [63:0]         h;
        int unsigned         span;
        logic [MAX_BITS-1:0] mask;
        logic [MAX_BITS-1:0] slot;
        int unsigned         probes;
        bit                  settled;
        verdict = '0;
        if (it.command == dhsg_pkg::CMD_CLEAR) begin
            // a new generation empties the set; on a wrap the stamps go too
            shadow_gen = shadow_gen + 1'b1;
            if (shadow_gen == '0) empty_shadow();
        end else begin
            span = 1 << live_bits();
            mask = MAX_BITS'(span - 1);
            // splitmix64 finaliser
            h = it.key + 64'h9E37_79B9_7F4A_7C15;
            h = (h ^ (h >> 30)) * 64'hBF58_476D_1CE4_E5B9;
            h = (h ^ (h >> 27)) * 64'h94D0_49BB_1331_11EB;
            h = h ^ (h >> 31);
            slot = h[MAX_BITS-1:0] & mask;
            settled = 1'b0;
            // linear probe: a stale stamp is a free slot, a current one holds a key
            for (probes = 0; probes < span && !settled; probes++) begin
                if (shadow_stamp[slot] != shadow_gen) begin
                    shadow_keys[slot]  = it.key;
                    shadow_stamp[slot] = shadow_gen;
                    verdict.is_new     = 1'b1;
                    settled            = 1'b1;
                end else if (shadow_keys[slot] == it.key) begin
                    settled = 1'b1;
                end else begin
                    slot = (slot + 1'b1) & mask;
                end
            end
            // every slot in use held some other key
            verdict.table_full = !settled;
        end
        owed_verdicts.insert(owed_verdicts.size(), verdict);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned draw_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm) return 0;
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Key for a random insert: mostly from the phase pool, some corner
    // patterns, the rest fresh
    function automatic logic [63:0] pick_key();
        int unsigned roll;
        logic [63:0] k;
        roll = $urandom_range(0, 99);
        if (roll < 70 && key_pool.size() > 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (roll < 80) begin
            case ($urandom_range(0, 3))
                0:       k = '0;
                1:       k = '1;
                2:       k = 64'd1 << $urandom_range(0, 63);
                default: k = ~(64'd1 << $urandom_range(0, 63));
            endcase
            return k;
        end
        return {$urandom, $urandom};
    endfunction

    function automatic void add_item(input logic cmd, input logic [63:0] key);
        dhsg_pkg::t_in_item it;
        it.command = cmd;
        it.key     = key;
        pending_items.insert(pending_items.size(), it);
        items_queued++;
    endfunction

    // Hold until every queued item has gone in and every verdict has come out
    task automatic settle();
        while (items_taken != items_queued || owed_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Size write, only with the block idle; it also empties the set
    task automatic write_size(input logic [TBW-1:0] code);
        settle();
        cfg_data  <= code;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_bits = code;
        empty_shadow();
    endtask

    // One random phase at a given size: mostly inserts, a clear now and then
    task automatic random_phase(input logic [TBW-1:0] code,
                                input int unsigned count, input bit quiet);
        int unsigned pool_n;
        write_size(code);
        calm = quiet;
        // pool twice the table, at most 48 keys, so small tables fill and overflow
        pool_n = 2 << live_bits();
        if (pool_n > 48) pool_n = 48;
        key_pool.delete();
        repeat (pool_n) key_pool.insert(key_pool.size(), {$urandom, $urandom});
        repeat (count) begin
            if ($urandom_range(0, 19) == 0)
                add_item(dhsg_pkg::CMD_CLEAR, {$urandom, $urandom});
            else
                add_item(dhsg_pkg::CMD_INSERT, pick_key());
        end
    endtask

    // ------------------------------------------------------------------------
    // Input driver: offer queued items, hold each until taken, idle between
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                judge_item(in_item);
                items_taken++;
            end
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    in_item  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    in_gap = draw_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: check each taken result against the oldest prediction,
    // stall the output at random
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        dhsg_pkg::t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (owed_verdicts.size() == 0) begin
                    $display("%0t: extra result, expected none, got %0b%0b",
                             $time, out_item.is_new, out_item.table_full);
                    mismatches++;
                end else begin
                    want = owed_verdicts.pop_front();
                    if (out_item.is_new !== want.is_new) begin
                        $display("%0t: is_new mismatch, expected %0b, got %0b",
                                 $time, want.is_new, out_item.is_new);
                        mismatches++;
                    end
                    if (out_item.table_full !== want.table_full) begin
                        $display("%0t: table_full mismatch, expected %0b, got %0b",
                                 $time, want.table_full, out_item.table_full);
                        mismatches++;
                    end
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                out_stall = draw_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no handshake of any kind happens for too long
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("** dedup_hash_set_generation: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [TBW-1:0] sizes [10];
        sizes = '{4'd15, 4'd1, 4'd3, 4'd10, 4'd0, 4'd6, 4'd2, 4'd12, 4'd4, 4'd9};
        // shadow state after reset
        empty_shadow();
        shadow_bits = dhsg_pkg::TABLE_BITS_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Full size after reset: extreme keys, a duplicate, a clear that
        // forgets, and the key whose first add gives a zero sum
        add_item(dhsg_pkg::CMD_INSERT, 64'd0);
        add_item(dhsg_pkg::CMD_INSERT, 64'd0);
        add_item(dhsg_pkg::CMD_INSERT, '1);
        add_item(dhsg_pkg::CMD_INSERT, 64'h8000_0000_0000_0000);
        add_item(dhsg_pkg::CMD_INSERT, '1);
        add_item(dhsg_pkg::CMD_CLEAR,  '1);
        add_item(dhsg_pkg::CMD_INSERT, 64'd0);
        add_item(dhsg_pkg::CMD_INSERT, 64'h61C8_8646_80B5_83EB);

        // Size zero reads as two slots: third distinct key finds the table full
        write_size(4'd0);
        add_item(dhsg_pkg::CMD_INSERT, 64'h0123_4567_89AB_CDEF);
        add_item(dhsg_pkg::CMD_INSERT, 64'hFEDC_BA98_7654_3210);
        add_item(dhsg_pkg::CMD_INSERT, 64'h5555_AAAA_3333_CCCC);
        add_item(dhsg_pkg::CMD_INSERT, 64'h0123_4567_89AB_CDEF);
        add_item(dhsg_pkg::CMD_INSERT, 64'hFEDC_BA98_7654_3210);
        add_item(dhsg_pkg::CMD_INSERT, 64'h5555_AAAA_3333_CCCC);
        add_item(dhsg_pkg::CMD_CLEAR,  64'd0);
        add_item(dhsg_pkg::CMD_INSERT, 64'h5555_AAAA_3333_CCCC);
        add_item(dhsg_pkg::CMD_CLEAR,  '1);

        // Generation wrap at four slots: stamp keys in generation one, clear
        // right round to the last generation, insert there, then wrap. Keys
        // stamped in the old generation one must read as absent afterwards.
        write_size(4'd2);
        calm = 1'b1;
        add_item(dhsg_pkg::CMD_INSERT, 64'h1111_2222_3333_4444);
        add_item(dhsg_pkg::CMD_INSERT, 64'h5555_6666_7777_8888);
        add_item(dhsg_pkg::CMD_INSERT, 64'h9999_AAAA_BBBB_CCCC);
        repeat ((1 << SBITS) - 2) add_item(dhsg_pkg::CMD_CLEAR, {$urandom, $urandom});
        add_item(dhsg_pkg::CMD_INSERT, 64'hDDDD_EEEE_FFFF_0000);
        add_item(dhsg_pkg::CMD_INSERT, 64'hDDDD_EEEE_FFFF_0000);
        add_item(dhsg_pkg::CMD_CLEAR,  64'd0);
        add_item(dhsg_pkg::CMD_INSERT, 64'h1111_2222_3333_4444);
        add_item(dhsg_pkg::CMD_INSERT, 64'h5555_6666_7777_8888);
        add_item(dhsg_pkg::CMD_INSERT, 64'h9999_AAAA_BBBB_CCCC);
        add_item(dhsg_pkg::CMD_INSERT, 64'hDDDD_EEEE_FFFF_0000);
        add_item(dhsg_pkg::CMD_INSERT, 64'h0F0F_0F0F_0F0F_0F0F);

        // Random phases across the size settings; every fourth runs without idling
        foreach (sizes[p]) random_phase(sizes[p], 100, (p % 4) == 3);

        settle();
        if (mismatches == 0) begin
            $display("** dedup_hash_set_generation: PASSED **");
        end else begin
            $display("** dedup_hash_set_generation: FAILED **");
        end
        $finish;
    end

endmodule

@@ dedup_hash_set_generation.f @@
rtl/dhsg_pkg.sv
rtl/dhsg_ram.sv
rtl/dhsg_hash.sv
rtl/dedup_hash_set_generation.sv
bench/dedup_hash_set_generation_tb.sv
